// File: rtl/label_region_mean_accumulator_macros.svh
`ifndef LABEL_REGION_MEAN_ACCUMULATOR_MACROS_SVH
`define LABEL_REGION_MEAN_ACCUMULATOR_MACROS_SVH
// Assertion helpers: synchronous active-high reset disables checking.
`define LRMA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LRMA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/lrma_pkg.sv
package lrma_pkg;
   localparam int MaxLabels = 1024;
   localparam int LabelBits = 10;
   localparam int CoordBits = 12;
   localparam int CountBits = 20;
   localparam int ChanBits = 8;
   localparam int ChanSumBits = 28;
   localparam int CoordSumBits = 32;
   // one memory word: sums, count and saturation flag
   localparam int EntryBits = 3 * ChanSumBits + 2 * CoordSumBits + CountBits + 1;
   localparam int DivSteps = CoordSumBits;
   localparam int StepBits = $clog2(DivSteps + 1);

   typedef struct packed {
      logic [ChanSumBits-1:0]  sum_a;
      logic [ChanSumBits-1:0]  sum_b;
      logic [ChanSumBits-1:0]  sum_c;
      logic [CoordSumBits-1:0] sum_x;
      logic [CoordSumBits-1:0] sum_y;
      logic [CountBits-1:0]    count;
      logic                    sat;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_DIVIDE, ST_RESPOND
   } state_type;

   typedef struct packed {
      logic clear_write;   // write zero at sweep address
      logic capture;       // latch request word
      logic mem_read;      // issue read of request label
      logic update_write;  // write accumulated / cleared entry
      logic div_start;     // load divider
      logic div_step;      // one restoring step
      logic rsp_load;      // load result register
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic is_read;
      logic in_range;
      logic div_done;
   } status_type;
endpackage

// File: rtl/label_region_mean_accumulator.sv
// Accumulate word: accept, memory read, read-modify-write; no new word is taken until it is done.
// Read word: memory read, entry clear, 32 divider steps plus the done check, then result load;
// no new word is taken until the result is loaded.
// Five quotients share one divisor, the count, in parallel restoring dividers, one bit per cycle.
// Result waits in an output register until taken.
// Reset is synchronous, active high; afterwards a clearing pass over all 1024 entries
// zeroes the label store while req_ready stays low.
module label_region_mean_accumulator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic [lrma_pkg::LabelBits-1:0]         req_label,
   input  logic [lrma_pkg::ChanBits-1:0]          req_chan_a,
   input  logic [lrma_pkg::ChanBits-1:0]          req_chan_b,
   input  logic [lrma_pkg::ChanBits-1:0]          req_chan_c,
   input  logic [lrma_pkg::CoordBits-1:0]         req_pos_x,
   input  logic [lrma_pkg::CoordBits-1:0]         req_pos_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [lrma_pkg::LabelBits-1:0]         rsp_out_label,
   output logic [lrma_pkg::ChanBits-1:0]          rsp_mean_a,
   output logic [lrma_pkg::ChanBits-1:0]          rsp_mean_b,
   output logic [lrma_pkg::ChanBits-1:0]          rsp_mean_c,
   output logic [lrma_pkg::CoordBits-1:0]         rsp_mean_x,
   output logic [lrma_pkg::CoordBits-1:0]         rsp_mean_y,
   output logic [lrma_pkg::CountBits-1:0]         rsp_pixel_count,
   output logic                                   rsp_overflow
);
   import lrma_pkg::*;
`include "label_region_mean_accumulator_macros.svh"

   cmd_type    cmd;
   status_type status;

   // sequencer: clear sweep, then one word at a time
   lrma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // label store, accumulate adders and shared divider
   lrma_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_label       (req_label),
      .req_chan_a      (req_chan_a),
      .req_chan_b      (req_chan_b),
      .req_chan_c      (req_chan_c),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .rsp_out_label   (rsp_out_label),
      .rsp_mean_a      (rsp_mean_a),
      .rsp_mean_b      (rsp_mean_b),
      .rsp_mean_c      (rsp_mean_c),
      .rsp_mean_x      (rsp_mean_x),
      .rsp_mean_y      (rsp_mean_y),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_overflow    (rsp_overflow)
   );

   // a new word is never taken while a write or the divider is busy
   `LRMA_ASSERT_IMPL(a_no_accept_busy, clock, reset, req_ready, !cmd.div_step && !cmd.update_write)
   // loading a result never overwrites one still waiting
   `LRMA_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.rsp_load, !rsp_valid || rsp_ready)
   // a loaded result shows valid next cycle
   `LRMA_ASSERT_NEXT(a_load_valid, clock, reset, cmd.rsp_load, rsp_valid)
endmodule

// File: rtl/lrma_ram.sv
module lrma_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/lrma_ctrl.sv
module lrma_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lrma_pkg::status_type status,
   output lrma_pkg::cmd_type    cmd
);
   import lrma_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (status.sweep_last) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_READ;
         ST_READ:    state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (!status.is_read) state_in = ST_IDLE;
            else if (status.in_range) state_in = ST_DIVIDE;
            else state_in = ST_RESPOND;
         end
         ST_DIVIDE:  if (status.div_done) state_in = ST_RESPOND;
         ST_RESPOND: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:   cmd.clear_write = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
            cmd.mem_read = req_valid;
         end
         ST_READ:    ;
         ST_UPDATE: begin
            cmd.update_write = status.in_range;
            cmd.div_start = status.is_read;
         end
         ST_DIVIDE:  cmd.div_step = !status.div_done;
         ST_RESPOND: cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default:    ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: rtl/lrma_datapath.sv
module lrma_datapath (
   input  logic                                          clock,
   input  logic                                          reset,
   input  lrma_pkg::cmd_type                             cmd,
   output lrma_pkg::status_type                          status,
   input  logic                                          req_cmd,
   input  logic [lrma_pkg::LabelBits-1:0]                req_label,
   input  logic [lrma_pkg::ChanBits-1:0]                 req_chan_a,
   input  logic [lrma_pkg::ChanBits-1:0]                 req_chan_b,
   input  logic [lrma_pkg::ChanBits-1:0]                 req_chan_c,
   input  logic [lrma_pkg::CoordBits-1:0]                req_pos_x,
   input  logic [lrma_pkg::CoordBits-1:0]                req_pos_y,
   output logic [lrma_pkg::LabelBits-1:0]                rsp_out_label,
   output logic [lrma_pkg::ChanBits-1:0]                 rsp_mean_a,
   output logic [lrma_pkg::ChanBits-1:0]                 rsp_mean_b,
   output logic [lrma_pkg::ChanBits-1:0]                 rsp_mean_c,
   output logic [lrma_pkg::CoordBits-1:0]                rsp_mean_x,
   output logic [lrma_pkg::CoordBits-1:0]                rsp_mean_y,
   output logic [lrma_pkg::CountBits-1:0]                rsp_pixel_count,
   output logic                                          rsp_overflow
);
   import lrma_pkg::*;

   localparam int AddrBits = $clog2(MaxLabels);
   localparam logic [CountBits-1:0] CountMax = '1;

   logic [AddrBits-1:0] sweep_ff, sweep_in;
   logic                cmd_ff;
   logic [LabelBits-1:0] label_ff;
   logic [ChanBits-1:0]  a_ff, b_ff, c_ff;
   logic [CoordBits-1:0] x_ff, y_ff;
   entry_type            rd_entry, new_entry, hold_ff;
   logic                 wr_en;
   logic [AddrBits-1:0]  wr_addr;
   entry_type            wr_data;
   logic                 in_range;

   // five quotients share one divisor and run in parallel bit-serially
   logic [CoordSumBits-1:0] q_ff [5];
   logic [CoordSumBits-1:0] r_ff [5];
   logic [CoordSumBits-1:0] divisor_ff;
   logic [StepBits-1:0]     step_ff;

   logic [LabelBits-1:0] o_label_ff;
   logic [ChanBits-1:0]  o_a_ff, o_b_ff, o_c_ff;
   logic [CoordBits-1:0] o_x_ff, o_y_ff;
   logic [CountBits-1:0] o_cnt_ff;
   logic                 o_ovf_ff;

   assign in_range = ({{(32-LabelBits){1'b0}}, label_ff} < 32'(MaxLabels));

   always_comb begin
      sweep_in = sweep_ff + AddrBits'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else if (cmd.clear_write) sweep_ff <= sweep_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         label_ff <= req_label;
         a_ff <= req_chan_a;
         b_ff <= req_chan_b;
         c_ff <= req_chan_c;
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
      end
   end

   always_comb begin
      new_entry = rd_entry;
      if (cmd_ff) begin
         new_entry = '0;
      end else if (rd_entry.count == CountMax) begin
         new_entry.sat = 1'b1;
      end else begin
         new_entry.sum_a = rd_entry.sum_a + ChanSumBits'(a_ff);
         new_entry.sum_b = rd_entry.sum_b + ChanSumBits'(b_ff);
         new_entry.sum_c = rd_entry.sum_c + ChanSumBits'(c_ff);
         new_entry.sum_x = rd_entry.sum_x + CoordSumBits'(x_ff);
         new_entry.sum_y = rd_entry.sum_y + CoordSumBits'(y_ff);
         new_entry.count = rd_entry.count + CountBits'(1);
      end
   end

   assign wr_en = cmd.clear_write || cmd.update_write;
   assign wr_addr = cmd.clear_write ? sweep_ff : label_ff[AddrBits-1:0];
   assign wr_data = cmd.clear_write ? entry_type'('0) : new_entry;

   lrma_ram #(.Width(EntryBits), .Depth(MaxLabels)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (req_label[AddrBits-1:0]),
      .rd_data (rd_entry)
   );

   // restoring division, one quotient bit per cycle, MSB first
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         hold_ff <= in_range ? rd_entry : entry_type'('0);
         divisor_ff <= (rd_entry.count == '0) ? CoordSumBits'(1)
                                              : CoordSumBits'(rd_entry.count);
         q_ff[0] <= CoordSumBits'(rd_entry.sum_a);
         q_ff[1] <= CoordSumBits'(rd_entry.sum_b);
         q_ff[2] <= CoordSumBits'(rd_entry.sum_c);
         q_ff[3] <= rd_entry.sum_x;
         q_ff[4] <= rd_entry.sum_y;
         for (int i = 0; i < 5; i++) r_ff[i] <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         for (int i = 0; i < 5; i++) begin
            logic [CoordSumBits:0] trial;
            trial = {r_ff[i], q_ff[i][CoordSumBits-1]} - {1'b0, divisor_ff};
            if (!trial[CoordSumBits]) begin
               r_ff[i] <= trial[CoordSumBits-1:0];
               q_ff[i] <= {q_ff[i][CoordSumBits-2:0], 1'b1};
            end else begin
               r_ff[i] <= {r_ff[i][CoordSumBits-2:0], q_ff[i][CoordSumBits-1]};
               q_ff[i] <= {q_ff[i][CoordSumBits-2:0], 1'b0};
            end
         end
         step_ff <= step_ff + StepBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         o_label_ff <= label_ff;
         if (in_range) begin
            o_a_ff <= q_ff[0][ChanBits-1:0];
            o_b_ff <= q_ff[1][ChanBits-1:0];
            o_c_ff <= q_ff[2][ChanBits-1:0];
            o_x_ff <= q_ff[3][CoordBits-1:0];
            o_y_ff <= q_ff[4][CoordBits-1:0];
            o_cnt_ff <= hold_ff.count;
            o_ovf_ff <= hold_ff.sat;
         end else begin
            o_a_ff <= '0;
            o_b_ff <= '0;
            o_c_ff <= '0;
            o_x_ff <= '0;
            o_y_ff <= '0;
            o_cnt_ff <= '0;
            o_ovf_ff <= 1'b0;
         end
      end
   end

   assign status.sweep_last = (sweep_ff == AddrBits'(MaxLabels - 1));
   assign status.is_read = cmd_ff;
   assign status.in_range = in_range;
   assign status.div_done = (step_ff == StepBits'(DivSteps));

   assign rsp_out_label = o_label_ff;
   assign rsp_mean_a = o_a_ff;
   assign rsp_mean_b = o_b_ff;
   assign rsp_mean_c = o_c_ff;
   assign rsp_mean_x = o_x_ff;
   assign rsp_mean_y = o_y_ff;
   assign rsp_pixel_count = o_cnt_ff;
   assign rsp_overflow = o_ovf_ff;
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lrma_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int LongHold = 300;

   // Command codes of the request word
   localparam logic CmdAccumulate = 1'b0;
   localparam logic CmdReadClear  = 1'b1;

   typedef struct {
      logic [LabelBits-1:0] label;
      logic [ChanBits-1:0]  mean_a;
      logic [ChanBits-1:0]  mean_b;
      logic [ChanBits-1:0]  mean_c;
      logic [CoordBits-1:0] mean_x;
      logic [CoordBits-1:0] mean_y;
      logic [CountBits-1:0] count;
      logic                 overflow;
   } region_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = 1'b0;
   logic [LabelBits-1:0] req_label = '0;
   logic [ChanBits-1:0]  req_chan_a = '0;
   logic [ChanBits-1:0]  req_chan_b = '0;
   logic [ChanBits-1:0]  req_chan_c = '0;
   logic [CoordBits-1:0] req_pos_x = '0;
   logic [CoordBits-1:0] req_pos_y = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [LabelBits-1:0] rsp_out_label;
   logic [ChanBits-1:0]  rsp_mean_a;
   logic [ChanBits-1:0]  rsp_mean_b;
   logic [ChanBits-1:0]  rsp_mean_c;
   logic [CoordBits-1:0] rsp_mean_x;
   logic [CoordBits-1:0] rsp_mean_y;
   logic [CountBits-1:0] rsp_pixel_count;
   logic                 rsp_overflow;

   // Shadow copy of the label store
   logic [ChanSumBits-1:0]  shadow_sum_a [MaxLabels];
   logic [ChanSumBits-1:0]  shadow_sum_b [MaxLabels];
   logic [ChanSumBits-1:0]  shadow_sum_c [MaxLabels];
   logic [CoordSumBits-1:0] shadow_sum_x [MaxLabels];
   logic [CoordSumBits-1:0] shadow_sum_y [MaxLabels];
   logic [CountBits-1:0]    shadow_count [MaxLabels];
   logic                    shadow_sat   [MaxLabels];

   region_stats_type pending_stats[$];

   int  error_count = 0;
   int  words_sent = 0;
   int  reads_sent = 0;
   int  stats_checked = 0;
   int  idle_cycles = 0;
   bit  idling_on = 1'b1;
   int  hold_request = 0;

   label_region_mean_accumulator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one accepted word to the shadow store; a read yields one expected result.
   function automatic void predict_region(input logic cmd, input logic [LabelBits-1:0] lab,
                                          input logic [ChanBits-1:0] a, b, c,
                                          input logic [CoordBits-1:0] x, y);
      region_stats_type s;
      logic [CountBits-1:0] div;
      if (cmd == CmdAccumulate) begin
         if (shadow_count[lab] == {CountBits{1'b1}}) begin
            shadow_sat[lab] = 1'b1;
         end else begin
            shadow_sum_a[lab] = shadow_sum_a[lab] + ChanSumBits'(a);
            shadow_sum_b[lab] = shadow_sum_b[lab] + ChanSumBits'(b);
            shadow_sum_c[lab] = shadow_sum_c[lab] + ChanSumBits'(c);
            shadow_sum_x[lab] = shadow_sum_x[lab] + CoordSumBits'(x);
            shadow_sum_y[lab] = shadow_sum_y[lab] + CoordSumBits'(y);
            shadow_count[lab] = shadow_count[lab] + CountBits'(1);
         end
         return;
      end
      div = (shadow_count[lab] == '0) ? CountBits'(1) : shadow_count[lab];
      s.label    = lab;
      s.mean_a   = ChanBits'(shadow_sum_a[lab] / ChanSumBits'(div));
      s.mean_b   = ChanBits'(shadow_sum_b[lab] / ChanSumBits'(div));
      s.mean_c   = ChanBits'(shadow_sum_c[lab] / ChanSumBits'(div));
      s.mean_x   = CoordBits'(shadow_sum_x[lab] / CoordSumBits'(div));
      s.mean_y   = CoordBits'(shadow_sum_y[lab] / CoordSumBits'(div));
      s.count    = shadow_count[lab];
      s.overflow = shadow_sat[lab];
      pending_stats.push_back(s);
      shadow_sum_a[lab] = '0;
      shadow_sum_b[lab] = '0;
      shadow_sum_c[lab] = '0;
      shadow_sum_x[lab] = '0;
      shadow_sum_y[lab] = '0;
      shadow_count[lab] = '0;
      shadow_sat[lab]   = 1'b0;
   endfunction

   // Offer one word; hold valid and payload until the handshake completes.
   task automatic send_word(input logic cmd, input logic [LabelBits-1:0] lab,
                            input logic [ChanBits-1:0] a, b, c,
                            input logic [CoordBits-1:0] x, y);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_label  <= lab;
      req_chan_a <= a;
      req_chan_b <= b;
      req_chan_c <= c;
      req_pos_x  <= x;
      req_pos_y  <= y;
      do @(posedge clock); while (!req_ready);
      predict_region(cmd, lab, a, b, c, x, y);
      words_sent++;
      if (cmd == CmdReadClear) reads_sent++;
   endtask

   task automatic send_pixel(input logic [LabelBits-1:0] lab, input logic [ChanBits-1:0] a, b, c,
                             input logic [CoordBits-1:0] x, y);
      send_word(CmdAccumulate, lab, a, b, c, x, y);
   endtask

   // Random pixel fields for one word.
   task automatic send_random_pixel(input logic [LabelBits-1:0] lab);
      send_pixel(lab, ChanBits'($urandom), ChanBits'($urandom), ChanBits'($urandom),
                 CoordBits'($urandom), CoordBits'($urandom));
   endtask

   // Read words carry random junk in the pixel fields; the block must ignore it.
   task automatic send_read(input logic [LabelBits-1:0] lab);
      send_word(CmdReadClear, lab, ChanBits'($urandom), ChanBits'($urandom),
                ChanBits'($urandom), CoordBits'($urandom), CoordBits'($urandom));
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   // Random word: mostly pixels on a few hot labels, reads about one word in eight.
   task automatic send_random_word(input logic [LabelBits-1:0] hot[4]);
      logic [LabelBits-1:0] lab;
      lab = ($urandom_range(0, 4) == 0) ? LabelBits'($urandom) : hot[$urandom_range(0, 3)];
      if ($urandom_range(0, 7) == 0) send_read(lab);
      else send_random_pixel(lab);
   endtask

   task automatic test_directed();
      // extremes on the lowest and highest label
      send_pixel(LabelBits'(0), 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF);
      send_pixel(LabelBits'(0), 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF);
      send_pixel(LabelBits'(MaxLabels - 1), 8'h00, 8'h00, 8'h00, 12'h000, 12'h000);
      send_pixel(LabelBits'(MaxLabels - 1), 8'hFF, 8'h00, 8'hFF, 12'hFFF, 12'h000);
      send_read(LabelBits'(0));
      send_read(LabelBits'(MaxLabels - 1));
      // read again right after clear, then an untouched label: empty entries
      send_read(LabelBits'(0));
      send_read(LabelBits'(517));
      // three pixels whose means truncate
      send_pixel(LabelBits'(1), 8'd1, 8'd2, 8'd254, 12'd1, 12'd4094);
      send_pixel(LabelBits'(1), 8'd0, 8'd2, 8'd255, 12'd2, 12'd4095);
      send_pixel(LabelBits'(1), 8'd0, 8'd3, 8'd255, 12'd2, 12'd4095);
      send_read(LabelBits'(1));
      send_pixel(LabelBits'(682), 8'hAA, 8'h55, 8'hAA, 12'hAAA, 12'h555);
      send_pixel(LabelBits'(341), 8'h55, 8'hAA, 8'h55, 12'h555, 12'hAAA);
      send_read(LabelBits'(682));
      send_read(LabelBits'(341));
      drop_valid();
      wait_drain();
   endtask

   task automatic test_random(input int n);
      logic [LabelBits-1:0] hot[4];
      foreach (hot[i]) hot[i] = LabelBits'($urandom);
      for (int i = 0; i < n; i++) begin
         if (i % 150 == 149) foreach (hot[j]) hot[j] = LabelBits'($urandom);
         send_random_word(hot);
      end
      drop_valid();
   endtask

   // Receiver holds off while the sender keeps offering; input must stall.
   task automatic test_backpressure();
      logic [LabelBits-1:0] hot[4];
      foreach (hot[i]) hot[i] = LabelBits'($urandom);
      hold_request = LongHold;
      for (int i = 0; i < 60; i++) begin
         if (i % 6 == 5) send_read(hot[i % 4]);
         else send_random_pixel(hot[i % 4]);
      end
      drop_valid();
   endtask

   // Sender pauses until every outstanding result is back, then resumes.
   task automatic test_pause_drain();
      send_random_pixel(LabelBits'(77));
      send_read(LabelBits'(77));
      send_read(LabelBits'(78));
      drop_valid();
      wait_drain();
      send_random_pixel(LabelBits'(77));
      send_read(LabelBits'(77));
      drop_valid();
   endtask

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            stall = hold_request;
            hold_request = 0;
            repeat (stall) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input longint expd, input longint act);
      if (expd != act) begin
         $error("%s mismatch: expected %0d, got %0d", name, expd, act);
         error_count++;
      end
   endtask

   // Compare each taken result with the oldest expectation.
   always @(posedge clock) begin
      region_stats_type s;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $error("unexpected result word for label %0d", rsp_out_label);
            error_count++;
         end else begin
            s = pending_stats.pop_front();
            check_field("out_label", s.label, rsp_out_label);
            check_field("mean_a", s.mean_a, rsp_mean_a);
            check_field("mean_b", s.mean_b, rsp_mean_b);
            check_field("mean_c", s.mean_c, rsp_mean_c);
            check_field("mean_x", s.mean_x, rsp_mean_x);
            check_field("mean_y", s.mean_y, rsp_mean_y);
            check_field("pixel_count", s.count, rsp_pixel_count);
            check_field("overflow", s.overflow, rsp_overflow);
            stats_checked++;
         end
      end
   end

   // Watchdog: end the run after too long without any handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Timeout: no handshake for %0d cycles", WatchdogLimit);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MaxLabels; i++) begin
         shadow_sum_a[i] = '0;
         shadow_sum_b[i] = '0;
         shadow_sum_c[i] = '0;
         shadow_sum_x[i] = '0;
         shadow_sum_y[i] = '0;
         shadow_count[i] = '0;
         shadow_sat[i]   = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(900);
      test_backpressure();
      test_pause_drain();
      // last stretch runs at full rate on both sides
      wait_drain();
      idling_on = 1'b0;
      test_random(200);

      wait_drain();
      repeat (60) @(posedge clock);
      $display("Sent %0d words (%0d reads), checked %0d region results.",
               words_sent, reads_sent, stats_checked);
      $display("Covered extremes, empty and re-read labels, long output stall, drain pause.");
      if (error_count == 0 && pending_stats.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// File: label_region_mean_accumulator.f
+incdir+rtl
rtl/lrma_pkg.sv
rtl/lrma_ram.sv
rtl/lrma_ctrl.sv
rtl/lrma_datapath.sv
rtl/label_region_mean_accumulator.sv
tb/testbench.sv
